[src/llsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llsp_pkg
// Shared widths, codes and types of the least loaded server picker.
// ----------------------------------------------------------------------------
package llsp_pkg;

  localparam int MAX_SERVERS = 16;
  localparam int IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int ID_W     = 16;
  localparam int IDLE_W   = 7;
  localparam int SESS_W   = 15;
  localparam int SUM_W    = SESS_W + 1;
  localparam int USES_W   = 32;

  localparam logic [ID_W-1:0] NO_SERVER = 16'hFFFF;

  typedef enum logic [OP_W-1:0] {
    OP_UPDATE = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PICK   = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_APPLY = 2'd2
  } state_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_INC   = 2'd2
  } cmd_kind_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic              free;
    logic [IDX_W-1:0]  free_idx;
    logic              found;
    logic [IDX_W-1:0]  best_idx;
    logic [IDLE_W-1:0] best_idle;
    logic [SUM_W-1:0]  best_sum;
    logic [SESS_W-1:0] best_total;
    logic [ID_W-1:0]   best_id;
    logic [USES_W-1:0] best_uses;
  } tok_t;

  // table write command broadcast to all cells
  typedef struct packed {
    logic              en;
    cmd_kind_t         kind;
    logic [IDX_W-1:0]  slot;
    logic [ID_W-1:0]   id;
    logic [IDLE_W-1:0] idle;
    logic [SESS_W-1:0] cur;
    logic [SESS_W-1:0] total;
    logic [USES_W-1:0] uses;
  } cmd_t;

endpackage

[src/llsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llsp_if
// Request and result channels of the least loaded server picker.
// ----------------------------------------------------------------------------
interface llsp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] server_id;
  logic [6:0]  idle_percent;
  logic [14:0] current_sessions;
  logic [14:0] total_sessions;
  logic [31:0] use_count_in;

  modport source (output valid, op, server_id, idle_percent, current_sessions,
                  total_sessions, use_count_in, input ready);
  modport sink   (input valid, op, server_id, idle_percent, current_sessions,
                  total_sessions, use_count_in, output ready);
endinterface

interface llsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] chosen_id;
  logic [31:0] use_count_out;

  modport source (output valid, status, chosen_id, use_count_out, input ready);
  modport sink   (input valid, status, chosen_id, use_count_out, output ready);
endinterface

[src/llsp_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llsp_cell
// One table slot: holds a server report and folds it into the passing token.
// ----------------------------------------------------------------------------
module llsp_cell
  import llsp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic [ID_W-1:0]  req_id,
  input  cmd_t             cmd,
  input  logic             tk_vld_in,
  input  tok_t             tk_in,
  output logic             tk_vld_out,
  output tok_t             tk_out
);

  logic              valid_r, valid_nxt;
  logic [ID_W-1:0]   id_r;
  logic [IDLE_W-1:0] idle_r;
  logic [SESS_W-1:0] cur_r;
  logic [SESS_W-1:0] total_r;
  logic [USES_W-1:0] uses_r;
  logic              tk_vld_r;
  tok_t              tk_r, tk_nxt;
  logic              sel;
  logic [SUM_W-1:0]  sum;
  logic              better;

  assign sel = cmd.en && (cmd.slot == cell_idx);
  assign sum = {1'b0, cur_r} + {1'b0, total_r};

  always_comb begin
    if (idle_r != tk_in.best_idle) begin
      better = idle_r > tk_in.best_idle;
    end else if (sum != tk_in.best_sum) begin
      better = sum < tk_in.best_sum;
    end else if (total_r != tk_in.best_total) begin
      better = total_r < tk_in.best_total;
    end else begin
      better = id_r < tk_in.best_id;
    end
  end

  always_comb begin
    tk_nxt = tk_in;
    if (!tk_in.hit && valid_r && (id_r == req_id)) begin
      tk_nxt.hit     = 1'b1;
      tk_nxt.hit_idx = cell_idx;
    end
    if (!tk_in.free && !valid_r) begin
      tk_nxt.free     = 1'b1;
      tk_nxt.free_idx = cell_idx;
    end
    if (valid_r && (!tk_in.found || better)) begin
      tk_nxt.found      = 1'b1;
      tk_nxt.best_idx   = cell_idx;
      tk_nxt.best_idle  = idle_r;
      tk_nxt.best_sum   = sum;
      tk_nxt.best_total = total_r;
      tk_nxt.best_id    = id_r;
      tk_nxt.best_uses  = uses_r;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (sel) begin
      case (cmd.kind)
        CMD_WRITE: valid_nxt = 1'b1;
        CMD_CLEAR: valid_nxt = 1'b0;
        default:   valid_nxt = valid_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      tk_vld_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      tk_vld_r <= tk_vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (tk_vld_in) begin
      tk_r <= tk_nxt;
    end
    if (sel && (cmd.kind == CMD_WRITE)) begin
      id_r    <= cmd.id;
      idle_r  <= cmd.idle;
      cur_r   <= cmd.cur;
      total_r <= cmd.total;
      uses_r  <= cmd.uses;
    end else if (sel && (cmd.kind == CMD_INC)) begin
      uses_r <= uses_r + USES_W'(1);
    end
  end

  assign tk_vld_out = tk_vld_r;
  assign tk_out     = tk_r;

endmodule

[src/least_loaded_server_picker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_server_picker
// Server load table with update, remove and least loaded pick.
// ----------------------------------------------------------------------------
// A request passes these steps in order: the transfer in the idle state, a
// launch register, the token register of each slot cell in turn while a scan
// token walks the chain of slot cells (each cell compares its entry against
// the token), the register that latches the finished token, and an apply step
// that writes the table and loads the result register. Ready returns and the
// result shows together, once the apply step fires; the result may wait in its
// register while the next request is taken, and the apply step holds only when
// that register is still full.
// ----------------------------------------------------------------------------
module least_loaded_server_picker
  import llsp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  llsp_in_if.sink         in_ch,
  llsp_out_if.source      out_ch
);

  state_t              state_r, state_nxt;
  logic                launch_r;
  logic [OP_W-1:0]     req_op_r;
  logic [ID_W-1:0]     req_id_r;
  logic [IDLE_W-1:0]   req_idle_r;
  logic [SESS_W-1:0]   req_cur_r;
  logic [SESS_W-1:0]   req_total_r;
  logic [USES_W-1:0]   req_uses_r;
  tok_t                fin_r;

  logic [MAX_SERVERS:0] tk_vld;
  tok_t                 tk_chain [MAX_SERVERS+1];

  cmd_t                cmd;
  logic                accept;
  logic                apply_fire;
  logic [STATUS_W-1:0] res_status;
  logic [ID_W-1:0]     res_id;
  logic [USES_W-1:0]   res_uses;

  logic                out_vld_r, out_vld_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [ID_W-1:0]     out_id_r;
  logic [USES_W-1:0]   out_uses_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign tk_vld[0]   = launch_r;
  assign tk_chain[0] = '0;

  for (genvar g = 0; g < MAX_SERVERS; g++) begin : g_cell
    llsp_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (IDX_W'(g)),
      .req_id     (req_id_r),
      .cmd        (cmd),
      .tk_vld_in  (tk_vld[g]),
      .tk_in      (tk_chain[g]),
      .tk_vld_out (tk_vld[g+1]),
      .tk_out     (tk_chain[g+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_SCAN;
      S_SCAN:  if (tk_vld[MAX_SERVERS]) state_nxt = S_APPLY;
      S_APPLY: if (apply_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    apply_fire = (state_r == S_APPLY) && (!out_vld_r || out_ch.ready);
    cmd        = '0;
    cmd.kind   = CMD_WRITE;
    cmd.id     = req_id_r;
    cmd.idle   = req_idle_r;
    cmd.cur    = req_cur_r;
    cmd.total  = req_total_r;
    cmd.uses   = req_uses_r;
    res_status = ST_OK;
    res_id     = NO_SERVER;
    res_uses   = '0;
    case (req_op_r)
      OP_UPDATE: begin
        if (fin_r.hit) begin
          cmd.en   = apply_fire;
          cmd.slot = fin_r.hit_idx;
        end else if (fin_r.free) begin
          cmd.en   = apply_fire;
          cmd.slot = fin_r.free_idx;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        cmd.en   = apply_fire && fin_r.hit;
        cmd.kind = CMD_CLEAR;
        cmd.slot = fin_r.hit_idx;
      end
      OP_PICK: begin
        cmd.kind = CMD_INC;
        cmd.slot = fin_r.best_idx;
        if (fin_r.found) begin
          cmd.en   = apply_fire;
          res_id   = fin_r.best_id;
          res_uses = fin_r.best_uses + USES_W'(1);
        end else begin
          res_status = ST_EMPTY;
        end
      end
      default: res_status = ST_OK;
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (apply_fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      launch_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      launch_r  <= accept;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op_r    <= in_ch.op;
      req_id_r    <= in_ch.server_id;
      req_idle_r  <= in_ch.idle_percent;
      req_cur_r   <= in_ch.current_sessions;
      req_total_r <= in_ch.total_sessions;
      req_uses_r  <= in_ch.use_count_in;
    end
    if (tk_vld[MAX_SERVERS]) begin
      fin_r <= tk_chain[MAX_SERVERS];
    end
    if (apply_fire) begin
      out_status_r <= res_status;
      out_id_r     <= res_id;
      out_uses_r   <= res_uses;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.chosen_id     = out_id_r;
  assign out_ch.use_count_out = out_uses_r;

  a_token_latency: assert property (@(posedge clk) disable iff (!rst_n)
    launch_r |-> ##MAX_SERVERS tk_vld[MAX_SERVERS])
    else $error("scan token did not reach the chain end on time");

  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tk_vld))
    else $error("more than one scan token in the chain");

  a_idle_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (tk_vld == '0))
    else $error("scan token in flight while idle");

  a_result_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> ($past(state_r) == S_APPLY))
    else $error("result loaded outside the apply step");

endmodule

[tb/least_loaded_server_picker_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_server_picker_test
// The bench sends update, remove and pick requests into the server load
// table, first a fixed opening sequence and then random traffic. It keeps
// its own copy of the table to work out each expected status, chosen server
// and use count, and compares every result against that prediction in
// order. The sender works in bursts with random gaps. The receiver stalls
// on changing patterns and, once, for a long stretch, so the block backs up.
// ----------------------------------------------------------------------------
module least_loaded_server_picker_test;
  import llsp_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1400;
  localparam int STALL_LIMIT     = 3000;
  localparam int DRAIN_CYCLES    = 2 * (MAX_SERVERS + 3);
  localparam int REPORT_MAX      = 10;
  localparam int HOLD_AFTER      = 500;
  localparam int HOLD_CYCLES     = 300;
  localparam int POOL_SIZE       = 24;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   id;
    logic [IDLE_W-1:0] idle;
    logic [SESS_W-1:0] cur;
    logic [SESS_W-1:0] total;
    logic [USES_W-1:0] uses;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [USES_W-1:0]   uses;
  } reply_t;

  class pick_table_scoreboard;
    logic              slot_valid [MAX_SERVERS];
    logic [ID_W-1:0]   slot_id    [MAX_SERVERS];
    logic [IDLE_W-1:0] slot_idle  [MAX_SERVERS];
    logic [SESS_W-1:0] slot_cur   [MAX_SERVERS];
    logic [SESS_W-1:0] slot_total [MAX_SERVERS];
    logic [USES_W-1:0] slot_uses  [MAX_SERVERS];
    reply_t            pending_replies [$];
    int                mismatches;

    function new();
      for (int i = 0; i < MAX_SERVERS; i++) begin
        slot_valid[i] = 1'b0;
        slot_id[i]    = '0;
        slot_idle[i]  = '0;
        slot_cur[i]   = '0;
        slot_total[i] = '0;
        slot_uses[i]  = '0;
      end
      mismatches = 0;
    endfunction

    function int find_slot(logic [ID_W-1:0] id);
      for (int i = 0; i < MAX_SERVERS; i++) begin
        if (slot_valid[i] && slot_id[i] == id) return i;
      end
      return -1;
    endfunction

    // true when slot a is the less loaded choice
    function bit outranks(int a, int b);
      logic [SUM_W-1:0] sum_a;
      logic [SUM_W-1:0] sum_b;
      sum_a = SUM_W'(slot_cur[a]) + SUM_W'(slot_total[a]);
      sum_b = SUM_W'(slot_cur[b]) + SUM_W'(slot_total[b]);
      if (slot_idle[a] != slot_idle[b]) return slot_idle[a] > slot_idle[b];
      if (sum_a != sum_b) return sum_a < sum_b;
      if (slot_total[a] != slot_total[b]) return slot_total[a] < slot_total[b];
      return slot_id[a] < slot_id[b];
    endfunction

    function void note_request(request_t req);
      reply_t rep;
      int     slot;
      rep.status = ST_OK;
      rep.id     = NO_SERVER;
      rep.uses   = '0;
      case (req.op)
        OP_UPDATE: begin
          slot = find_slot(req.id);
          if (slot < 0) begin
            for (int i = 0; i < MAX_SERVERS; i++) begin
              if (!slot_valid[i]) begin
                slot = i;
                break;
              end
            end
          end
          if (slot < 0) begin
            rep.status = ST_FULL;
          end else begin
            slot_valid[slot] = 1'b1;
            slot_id[slot]    = req.id;
            slot_idle[slot]  = req.idle;
            slot_cur[slot]   = req.cur;
            slot_total[slot] = req.total;
            slot_uses[slot]  = req.uses;
          end
        end
        OP_REMOVE: begin
          slot = find_slot(req.id);
          if (slot >= 0) slot_valid[slot] = 1'b0;
        end
        OP_PICK: begin
          slot = -1;
          for (int i = 0; i < MAX_SERVERS; i++) begin
            if (slot_valid[i] && (slot < 0 || outranks(i, slot))) slot = i;
          end
          if (slot < 0) begin
            rep.status = ST_EMPTY;
          end else begin
            slot_uses[slot] = slot_uses[slot] + USES_W'(1);
            rep.id          = slot_id[slot];
            rep.uses        = slot_uses[slot];
          end
        end
        default: ;
      endcase
      pending_replies.push_back(rep);
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        flag("unexpected result", 64'(0), 64'(got));
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status) flag("status", 64'(want.status), 64'(got.status));
      if (got.id !== want.id) flag("chosen_id", 64'(want.id), 64'(got.id));
      if (got.uses !== want.uses) flag("use_count_out", 64'(want.uses), 64'(got.uses));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  llsp_in_if  in_ch ();
  llsp_out_if out_ch ();

  least_loaded_server_picker DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  pick_table_scoreboard board = new();

  logic [ID_W-1:0] id_pool [POOL_SIZE];
  int              burst_left = 0;
  int              remove_weight = 20;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic offer(request_t req);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8);
    end
    in_ch.valid            <= 1'b1;
    in_ch.op               <= req.op;
    in_ch.server_id        <= req.id;
    in_ch.idle_percent     <= req.idle;
    in_ch.current_sessions <= req.cur;
    in_ch.total_sessions   <= req.total;
    in_ch.use_count_in     <= req.uses;
    do @(posedge clk); while (!in_ch.ready);
    board.note_request(req);
    burst_left--;
  endtask

  task automatic send(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [IDLE_W-1:0] idle,
                      logic [SESS_W-1:0] cur, logic [SESS_W-1:0] total,
                      logic [USES_W-1:0] uses);
    request_t req;
    req = '{op: op, id: id, idle: idle, cur: cur, total: total, uses: uses};
    offer(req);
  endtask

  function automatic logic [SESS_W-1:0] draw_sessions();
    case ($urandom_range(0, 3))
      0, 1:    return SESS_W'($urandom_range(0, 3));
      2:       return SESS_W'(15'h7FFF - $urandom_range(0, 2));
      default: return SESS_W'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic request_t random_request();
    request_t req;
    int       roll;
    roll = $urandom_range(0, 99);
    if (roll < 45)                      req.op = OP_UPDATE;
    else if (roll < 45 + remove_weight) req.op = OP_REMOVE;
    else if (roll < 96)                 req.op = OP_PICK;
    else                                req.op = OP_UNUSED;
    req.id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom) : id_pool[$urandom_range(0, POOL_SIZE-1)];
    case ($urandom_range(0, 4))
      0:       req.idle = 7'd0;
      1:       req.idle = 7'd100;
      2:       req.idle = 7'd127;
      3:       req.idle = IDLE_W'($urandom_range(95, 100));
      default: req.idle = IDLE_W'($urandom_range(0, 127));
    endcase
    req.cur   = draw_sessions();
    req.total = draw_sessions();
    req.uses  = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2) : $urandom;
    return req;
  endfunction

  // stimulus
  initial begin
    int sent;
    rst_n                  <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.op               <= OP_UPDATE;
    in_ch.server_id        <= '0;
    in_ch.idle_percent     <= '0;
    in_ch.current_sessions <= '0;
    in_ch.total_sessions   <= '0;
    in_ch.use_count_in     <= '0;
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = ID_W'($urandom);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send(OP_PICK, 16'h0000, 7'd0, 15'd0, 15'd0, 32'd0);
    send(OP_REMOVE, 16'h1234, 7'd0, 15'd0, 15'd0, 32'd0);
    send(OP_UNUSED, 16'hFFFF, 7'h7F, 15'h7FFF, 15'h7FFF, 32'hFFFF_FFFF);
    send(OP_UPDATE, 16'hFFFF, 7'd127, 15'h7FFF, 15'h7FFF, 32'hFFFF_FFFF);
    send(OP_PICK, 16'h0000, 7'd0, 15'd0, 15'd0, 32'd0);
    send(OP_UPDATE, 16'h0000, 7'd0, 15'd0, 15'd0, 32'd0);
    send(OP_PICK, 16'h0000, 7'd0, 15'd0, 15'd0, 32'd0);
    send(OP_REMOVE, 16'hFFFF, 7'd0, 15'd0, 15'd0, 32'd0);
    send(OP_PICK, 16'hFFFF, 7'd0, 15'd0, 15'd0, 32'd0);
    // equal sums broken by total, then full ties broken by id
    send(OP_UPDATE, 16'd10, 7'd100, 15'd2, 15'd3, 32'd100);
    send(OP_UPDATE, 16'd11, 7'd100, 15'd3, 15'd2, 32'd200);
    send(OP_PICK, 16'd0, 7'd0, 15'd0, 15'd0, 32'd0);
    send(OP_UPDATE, 16'd12, 7'd100, 15'd3, 15'd2, 32'd300);
    send(OP_PICK, 16'd0, 7'd0, 15'd0, 15'd0, 32'd0);
    send(OP_UPDATE, 16'd11, 7'd99, 15'd0, 15'd0, 32'd7);
    send(OP_PICK, 16'd0, 7'd0, 15'd0, 15'd0, 32'd0);
    // fill the table, then update a new id and an existing one
    for (int k = 0; k < MAX_SERVERS - 4; k++)
      send(OP_UPDATE, ID_W'(16'h0100 + k), IDLE_W'($urandom_range(0, 50)), 15'd5, 15'd5,
           32'd0);
    send(OP_UPDATE, 16'h0200, 7'd127, 15'd0, 15'd0, 32'd0);
    send(OP_UPDATE, 16'h0100, 7'd101, 15'd1, 15'd1, 32'd9);
    send(OP_PICK, 16'd0, 7'd0, 15'd0, 15'd0, 32'd0);

    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      request_t req;
      if (sent % 200 == 0) remove_weight = ($urandom_range(0, 1) == 0) ? 10 : 45;
      req = random_request();
      offer(req);
      if (req.op != OP_UNUSED) sent++;
    end
    in_ch.valid <= 1'b0;

    while (board.pending_replies.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("least_loaded_server_picker_test: done, clean");
    end else begin
      $display("least_loaded_server_picker_test: done, errors");
    end
    $finish;
  end

  // result side
  initial begin
    int  cycle_count;
    int  mode;
    int  replies_taken;
    int  hold_left;
    bit  held;
    logic take;
    cycle_count   = 0;
    mode          = 0;
    replies_taken = 0;
    hold_left     = 0;
    held          = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        board.check_reply('{status: out_ch.status, id: out_ch.chosen_id,
                            uses: out_ch.use_count_out});
        replies_taken++;
      end
      if (replies_taken == HOLD_AFTER && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (cycle_count % 48 == 0) mode = $urandom_range(0, 3);
      cycle_count++;
      case (mode)
        0:       take = 1'b1;
        1:       take = ($urandom_range(0, 3) != 0);
        2:       take = ($urandom_range(0, 3) == 0);
        default: take = cycle_count[0];
      endcase
      if (hold_left > 0) begin
        take = 1'b0;
        hold_left--;
      end
      out_ch.ready <= take;
    end
  end

  // watchdog
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("least_loaded_server_picker_test: done, errors");
        $finish;
      end
    end
  end

endmodule

[least_loaded_server_picker.f]
src/llsp_pkg.sv
src/llsp_if.sv
src/llsp_cell.sv
src/least_loaded_server_picker.sv
tb/least_loaded_server_picker_test.sv
